// ----- src/tpig_pkg.sv -----
package tpig_pkg;

	typedef enum logic [2:0] {
		REG_EDGE_SIZE    = 3'd0,
		REG_DETAIL_NORTH = 3'd1,
		REG_DETAIL_WEST  = 3'd2,
		REG_DETAIL_SOUTH = 3'd3,
		REG_DETAIL_EAST  = 3'd4
	} reg_idx_t;

	localparam logic [2:0] PH_CENTER = 3'd0;
	localparam logic [2:0] PH_NORTH  = 3'd1;
	localparam logic [2:0] PH_WEST   = 3'd2;
	localparam logic [2:0] PH_SOUTH  = 3'd3;
	localparam logic [2:0] PH_EAST   = 3'd4;
	localparam logic [2:0] PH_DONE   = 3'd5;

	localparam int VW = 15;

	typedef struct packed {
		logic [7:0] edge_size;
		logic [2:0] detail_north;
		logic [2:0] detail_west;
		logic [2:0] detail_south;
		logic [2:0] detail_east;
	} cfg_t;

	typedef struct packed {
		logic       valid;
		logic       restart;
	} req_t;

endpackage

// ----- src/tpig_front.sv -----
module tpig_front import tpig_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       in_restart,
	output req_t       req,
	input  logic       pop
);

	logic [1:0] count_q;
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] mem_q;
	logic       push;

	assign in_ready    = (count_q != 2'd2);
	assign push        = in_valid & in_ready;
	assign req.valid   = (count_q != 2'd0);
	assign req.restart = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= 2'd0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			case ({push, pop})
				2'b10: count_q <= count_q + 2'd1;
				2'b01: count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= in_restart;
	end

endmodule

// ----- src/tpig_engine.sv -----
module tpig_engine import tpig_pkg::*; #(
	parameter int MAX_EDGE   = 128,
	parameter int MAX_DETAIL = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  cfg_t          cfg,
	input  logic          cfg_wr,
	input  req_t          req,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [VW-1:0] vertex_a,
	output logic [VW-1:0] vertex_b,
	output logic [VW-1:0] vertex_c,
	output logic          valid_res,
	output logic          last
);

	typedef struct packed {
		logic [2:0] phase;
		logic [7:0] outer;
		logic [7:0] inner;
		logic [3:0] sub;
		logic [7:0] sstart;
		logic [1:0] lp;
	} gen_t;

	typedef struct packed {
		logic       emit;
		logic       done;
		logic       pos;
		gen_t       nxt;
		logic [8:0] p1, q1, p2, q2, p3, q3;
	} step_t;

	localparam gen_t S0 = '{phase: PH_CENTER, outer: 8'd0, inner: 8'd0, sub: 4'd0,
		sstart: 8'd1, lp: 2'd0};

	// row/col offsets of the eight triangles of an interior 2x2 block
	function automatic logic [11:0] blk(logic [2:0] s);
		case (s)
			3'd0: blk = {2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd1};
			3'd1: blk = {2'd0, 2'd0, 2'd1, 2'd1, 2'd1, 2'd0};
			3'd2: blk = {2'd1, 2'd0, 2'd1, 2'd1, 2'd2, 2'd0};
			3'd3: blk = {2'd2, 2'd0, 2'd1, 2'd1, 2'd2, 2'd1};
			3'd4: blk = {2'd0, 2'd1, 2'd0, 2'd2, 2'd1, 2'd1};
			3'd5: blk = {2'd1, 2'd1, 2'd0, 2'd2, 2'd1, 2'd2};
			3'd6: blk = {2'd1, 2'd1, 2'd1, 2'd2, 2'd2, 2'd2};
			default: blk = {2'd1, 2'd1, 2'd2, 2'd2, 2'd2, 2'd1};
		endcase
	endfunction

	function automatic logic [2:0] dsel(logic [2:0] ph, cfg_t c);
		case (ph)
			PH_NORTH: dsel = c.detail_north;
			PH_WEST:  dsel = c.detail_west;
			PH_SOUTH: dsel = c.detail_south;
			default:  dsel = c.detail_east;
		endcase
	endfunction

	function automatic gen_t next_phase(gen_t g);
		gen_t n;
		n = S0;
		n.phase = g.phase + 3'd1;
		return n;
	endfunction

	function automatic step_t gen_step(gen_t g, logic [2:0] le, logic [2:0] d, logic full);
		step_t      s;
		logic [8:0] e, half, n, x, y, i, hy, stp, lim, oc, ic;
		logic [2:0] sh;
		logic [11:0] t;
		s = '0;
		s.nxt = g;
		e = 9'd1 << le;
		half = e >> 1;
		n = half - 9'd1;
		oc = {1'b0, g.outer};
		ic = {1'b0, g.inner};
		sh = (d > le) ? le : d;
		stp = 9'd1 << sh;
		lim = e >> sh;
		y = oc << sh;
		hy = (stp >> 1) + y;
		t = blk(g.sub[2:0]);
		x = {g.outer, 1'b1};
		i = {g.inner, 1'b0} + {7'd0, g.lp};
		if (g.phase >= PH_DONE) begin
			s.done = 1'b1;
		end else if (g.phase == PH_CENTER) begin
			if (oc >= n) begin
				s.nxt = next_phase(g);
			end else if (ic >= n) begin
				s.nxt.outer = g.outer + 8'd1;
				s.nxt.inner = 8'd0;
				s.nxt.sub   = 4'd0;
			end else if (g.sub >= 4'd8) begin
				s.nxt.inner = g.inner + 8'd1;
				s.nxt.sub   = 4'd0;
			end else begin
				s.emit = 1'b1;
				y = {g.inner, 1'b1};
				s.p1 = x + {7'd0, t[11:10]}; s.q1 = y + {7'd0, t[9:8]};
				s.p2 = x + {7'd0, t[7:6]};   s.q2 = y + {7'd0, t[5:4]};
				s.p3 = x + {7'd0, t[3:2]};   s.q3 = y + {7'd0, t[1:0]};
				s.nxt.sub = g.sub + 4'd1;
			end
		end else if (full) begin
			lim = (g.lp == 2'd0) ? half : half - 9'd1;
			if (g.lp > 2'd1) begin
				s.nxt = next_phase(g);
			end else if (ic >= lim) begin
				if (g.lp == 2'd0) begin
					s.nxt.lp    = 2'd1;
					s.nxt.inner = 8'd0;
					s.nxt.sub   = 4'd0;
				end else begin
					s.nxt = next_phase(g);
				end
			end else if (g.sub >= 4'd2) begin
				s.nxt.inner = g.inner + 8'd1;
				s.nxt.sub   = 4'd0;
			end else begin
				s.emit = 1'b1;
				s.q2 = i + 9'd1;
				s.q3 = i + 9'd1;
				if (g.lp == 2'd0) begin
					if (g.sub == 4'd0) begin
						s.p1 = 9'd0; s.q1 = i;      s.p2 = 9'd0; s.p3 = 9'd1;
					end else begin
						s.p1 = 9'd0; s.q1 = i + 9'd2; s.p2 = 9'd1; s.p3 = 9'd0;
					end
				end else begin
					if (g.sub == 4'd0) begin
						s.p1 = 9'd1; s.q1 = i;      s.p2 = 9'd1; s.p3 = 9'd0;
						s.pos = 1'b1;
					end else begin
						s.p1 = 9'd1; s.q1 = i + 9'd2; s.p2 = 9'd1; s.p3 = 9'd0;
					end
				end
				s.nxt.sub = g.sub + 4'd1;
			end
		end else begin
			// stitched border, coarse edge vertices every stp cells
			if (g.lp == 2'd0) begin
				if (oc >= lim) begin
					s.nxt.lp    = 2'd1;
					s.nxt.inner = g.sstart;
				end else if (g.sub == 4'd0) begin
					s.emit = 1'b1;
					s.p1 = 9'd0; s.q1 = y;
					s.p2 = 9'd0; s.q2 = y + stp;
					s.p3 = 9'd1; s.q3 = hy;
					s.nxt.sub   = 4'd1;
					s.nxt.inner = g.sstart;
				end else if (ic < hy) begin
					s.emit = 1'b1;
					s.pos  = 1'b1;
					s.p1 = 9'd0; s.q1 = y;
					s.p2 = 9'd1; s.q2 = ic;
					s.p3 = 9'd1; s.q3 = ic + 9'd1;
					s.nxt.inner = g.inner + 8'd1;
				end else begin
					s.nxt.sstart = hy[7:0];
					s.nxt.outer  = g.outer + 8'd1;
					s.nxt.sub    = 4'd0;
				end
			end else if (g.lp == 2'd1 && ic < e - 9'd1) begin
				s.emit = 1'b1;
				s.pos  = 1'b1;
				s.p1 = 9'd0; s.q1 = e;
				s.p2 = 9'd1; s.q2 = ic;
				s.p3 = 9'd1; s.q3 = ic + 9'd1;
				s.nxt.inner = g.inner + 8'd1;
			end else begin
				s.nxt = next_phase(g);
			end
		end
		return s;
	endfunction

	function automatic logic [VW-1:0] vidx(logic [2:0] ph, logic [2:0] le,
		logic [8:0] p, logic [8:0] q);
		logic [8:0]  r, c, e;
		logic [15:0] v;
		e = 9'd1 << le;
		case (ph)
			PH_NORTH: begin r = q; c = p; end
			PH_SOUTH: begin r = q; c = e - p; end
			PH_EAST:  begin r = e - p; c = q; end
			default:  begin r = p; c = q; end
		endcase
		v = ({7'd0, r} << le) + {7'd0, r} + {7'd0, c};
		return v[VW-1:0];
	endfunction

	logic [7:0]    ev;
	logic [2:0]    le;
	gen_t          w_q, r_q, src;
	step_t         wst, sst;
	logic [2:0]    wd, sd;
	logic          wfull, sfull, settled, push, accept, swap;
	logic          pend_v_q, pend_vres_q;
	logic [VW-1:0] pend_a_q, pend_b_q, pend_c_q, tb, tc;
	logic          out_v_q, out_vres_q, out_last_q;
	logic [VW-1:0] out_a_q, out_b_q, out_c_q;

	// effective edge: clamp, then highest power of two at or below
	always_comb begin
		ev = cfg.edge_size;
		if (ev > 8'(MAX_EDGE)) ev = 8'(MAX_EDGE);
		if (ev < 8'd4) ev = 8'd4;
		le = 3'd2;
		for (int k = 3; k < 8; k++) begin
			if (ev[k]) le = 3'(k);
		end
	end

	assign src   = req.restart ? S0 : w_q;
	assign wd    = dsel(w_q.phase, cfg);
	assign sd    = dsel(src.phase, cfg);
	assign wfull = (wd == 3'd0) || (wd > 3'(MAX_DETAIL));
	assign sfull = (sd == 3'd0) || (sd > 3'(MAX_DETAIL));
	assign wst   = gen_step(w_q, le, wd, wfull);
	assign sst   = gen_step(src, le, sd, sfull);

	assign settled = wst.emit | wst.done;
	assign push    = settled & pend_v_q & (~out_v_q | out_ready);
	assign accept  = req.valid & settled & (~pend_v_q | push) & ~cfg_wr;
	assign pop     = accept;

	// sides mirrored by a swap flip the winding
	assign swap = sst.pos ^ ((src.phase == PH_NORTH) || (src.phase == PH_EAST));
	assign tb   = vidx(src.phase, le, sst.p2, sst.q2);
	assign tc   = vidx(src.phase, le, sst.p3, sst.q3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q      <= S0;
			r_q      <= S0;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (cfg_wr) begin
				w_q <= r_q;
			end else if (accept) begin
				if (sst.done) begin
					r_q <= w_q;
				end else begin
					r_q <= sst.nxt;
					w_q <= sst.nxt;
				end
			end else if (!settled) begin
				w_q <= wst.nxt;
			end
			if (accept) pend_v_q <= 1'b1;
			else if (push) pend_v_q <= 1'b0;
			if (push) out_v_q <= 1'b1;
			else if (out_ready) out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pend_vres_q <= ~sst.done;
			if (sst.done) begin
				pend_a_q <= '0;
				pend_b_q <= '0;
				pend_c_q <= '0;
			end else begin
				pend_a_q <= vidx(src.phase, le, sst.p1, sst.q1);
				pend_b_q <= swap ? tc : tb;
				pend_c_q <= swap ? tb : tc;
			end
		end
		if (push) begin
			out_a_q    <= pend_a_q;
			out_b_q    <= pend_b_q;
			out_c_q    <= pend_c_q;
			out_vres_q <= pend_vres_q;
			out_last_q <= pend_vres_q & wst.done;
		end
	end

	assign out_valid = out_v_q;
	assign vertex_a  = out_a_q;
	assign vertex_b  = out_b_q;
	assign vertex_c  = out_c_q;
	assign valid_res = out_vres_q;
	assign last      = out_last_q;

endmodule

// ----- src/terrain_patch_index_generator_top.sv -----
// Terrain patch index generator: each item on the input stream (bit 0 of tdata = restart)
// yields one triangle on the output stream, interior 2x2 blocks first, then the north, west,
// south and east border strips, stitched to coarser neighbours by the detail registers.
// A front queue of two items takes the input; the back walks the triangle order, one item per
// cycle with the next triangle following directly, while the output does not stall and no
// cfg write is under way; each bookkeeping step (block end, row end, strip end, phase change)
// holds items back. Results pass a pending and an output register. tuser carries valid_res
// (0 once the patch is exhausted, all vertices 0), tlast marks the final triangle. The user
// writes registers (cfg channel, always ready) only while the block is idle, unenforced.
module terrain_patch_index_generator_top import tpig_pkg::*; #(
	parameter int MAX_EDGE   = 128,
	parameter int MAX_DETAIL = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [0] restart
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,   // [14:0] vertex_a, [29:15] vertex_b, [44:30] vertex_c
	output logic        m_axis_tuser,   // [0] valid_res
	output logic        m_axis_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	cfg_t          cfg_q;
	req_t          req;
	logic          pop, cfg_wr;
	logic [VW-1:0] va, vb, vc;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid & cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{edge_size: 8'd16, detail_north: 3'd0, detail_west: 3'd0,
				detail_south: 3'd0, detail_east: 3'd0};
		end else if (cfg_wr) begin
			case (cfg_index)
				REG_EDGE_SIZE:    cfg_q.edge_size    <= cfg_data;
				REG_DETAIL_NORTH: cfg_q.detail_north <= cfg_data[2:0];
				REG_DETAIL_WEST:  cfg_q.detail_west  <= cfg_data[2:0];
				REG_DETAIL_SOUTH: cfg_q.detail_south <= cfg_data[2:0];
				REG_DETAIL_EAST:  cfg_q.detail_east  <= cfg_data[2:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	tpig_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_restart (s_axis_tdata[0]),
		.req        (req),
		.pop        (pop)
	);

	tpig_engine #(
		.MAX_EDGE   (MAX_EDGE),
		.MAX_DETAIL (MAX_DETAIL)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cfg_wr    (cfg_wr),
		.req       (req),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.vertex_a  (va),
		.vertex_b  (vb),
		.vertex_c  (vc),
		.valid_res (m_axis_tuser),
		.last      (m_axis_tlast)
	);

	assign m_axis_tdata = {3'd0, vc, vb, va};

endmodule
